/* design/tpu_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package tpu_pkg;

  localparam int unsigned FIELD_N = 5;

  // file note that means note off, and notes above it are dropped
  localparam logic [7:0] NOTE_OFF = 8'd97;
  // mask for a raw packet once the note byte has been taken
  localparam logic [FIELD_N-1:0] MASK_RAW = 5'b11110;

  localparam int unsigned CFG_INDEX_W = 1;
  localparam logic [CFG_INDEX_W-1:0] REG_KEY_OFF  = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] REG_EXPECTED = 1'b1;

  // one assembled packet on its way to the back end
  typedef struct packed {
    logic [FIELD_N-1:0][7:0] fields;
    logic                    last;
  } slot_t;

  typedef struct packed {
    logic [7:0]  key_off;
    logic [15:0] expected;
  } cfg_t;

endpackage

`default_nettype wire

/* design/tpu_front.sv */
`timescale 1ns / 1ps
`default_nettype none

module tpu_front (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          byte_valid,
  input  wire logic          byte_stall,
  input  wire logic [7:0]    data_byte,
  input  wire logic          final_byte,
  output tpu_pkg::slot_t     push_data,
  output logic               push_valid
);

  logic [tpu_pkg::FIELD_N-1:0]      mask_r, mask_nxt;
  logic                             in_pkt_r, in_pkt_nxt;
  logic [tpu_pkg::FIELD_N-1:0][7:0] held_r, held_nxt;

  logic [tpu_pkg::FIELD_N-1:0]      mask_upd;
  logic [tpu_pkg::FIELD_N-1:0][7:0] held_upd;
  logic                             accept;
  logic                             emit;

  assign accept = byte_valid && !byte_stall;

  // classify the byte: mask, raw note, or the next awaited field
  always_comb begin
    logic       found;
    logic [2:0] pos;
    found    = 1'b0;
    pos      = '0;
    held_upd = held_r;
    mask_upd = mask_r;
    if (!in_pkt_r) begin
      held_upd = '0;
      if (data_byte[7]) begin
        mask_upd = data_byte[tpu_pkg::FIELD_N-1:0];
      end else begin
        held_upd[0] = data_byte;
        mask_upd    = tpu_pkg::MASK_RAW;
      end
    end else begin
      // lowest awaited field takes the byte
      for (int i = 0; i < tpu_pkg::FIELD_N; i++) begin
        if (!found && mask_r[i]) begin
          found = 1'b1;
          pos   = 3'(i);
        end
      end
      if (found) begin
        held_upd[pos] = data_byte;
        mask_upd[pos] = 1'b0;
      end
    end
  end

  assign emit = (mask_upd == '0) || final_byte;

  always_comb begin
    mask_nxt   = mask_r;
    in_pkt_nxt = in_pkt_r;
    held_nxt   = held_r;
    if (accept) begin
      if (emit) begin
        mask_nxt   = '0;
        in_pkt_nxt = 1'b0;
        held_nxt   = '0;
      end else begin
        mask_nxt   = mask_upd;
        in_pkt_nxt = 1'b1;
        held_nxt   = held_upd;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r   <= '0;
      in_pkt_r <= 1'b0;
      held_r   <= '0;
    end else begin
      mask_r   <= mask_nxt;
      in_pkt_r <= in_pkt_nxt;
      held_r   <= held_nxt;
    end
  end

  assign push_valid       = accept && emit;
  assign push_data.fields = held_upd;
  assign push_data.last   = final_byte;

endmodule

`default_nettype wire

/* design/tpu_queue.sv */
`timescale 1ns / 1ps
`default_nettype none

module tpu_queue #(
  parameter int unsigned DEPTH = 2
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           push,
  input  wire tpu_pkg::slot_t push_data,
  input  wire logic           pop,
  output tpu_pkg::slot_t      pop_data,
  output logic                not_empty,
  output logic                full
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  tpu_pkg::slot_t    slots_r [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;

  assign not_empty = (count_r != '0);
  assign full      = (count_r == CNT_W'(DEPTH));
  assign pop_data  = slots_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

`default_nettype wire

/* design/tpu_back.sv */
`timescale 1ns / 1ps
`default_nettype none

module tpu_back (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire tpu_pkg::cfg_t  cfg,
  input  wire logic           slot_avail,
  input  wire tpu_pkg::slot_t slot_in,
  output logic                pop,
  output logic                out_valid,
  input  wire logic           out_stall,
  output logic [7:0]          note_value,
  output logic [7:0]          instrument_number,
  output logic [7:0]          volume_byte,
  output logic [7:0]          effect_kind,
  output logic [7:0]          effect_argument,
  output logic [15:0]         slot_number,
  output logic                last_slot,
  output logic                count_mismatch
);

  logic        valid_r, valid_nxt;
  logic [15:0] slot_cnt_r, slot_cnt_nxt;
  logic [7:0]  note_r, instr_r, vol_r, fx_r, arg_r;
  logic [15:0] number_r;
  logic        last_r, mismatch_r;

  logic [7:0]  note_fix;
  logic [15:0] count_inc;
  logic        mismatch;

  assign pop = slot_avail && (!valid_r || !out_stall);

  always_comb begin
    if (slot_in.fields[0] > tpu_pkg::NOTE_OFF) begin
      note_fix = '0;
    end else if (slot_in.fields[0] == tpu_pkg::NOTE_OFF) begin
      note_fix = cfg.key_off;
    end else begin
      note_fix = slot_in.fields[0];
    end
  end

  assign count_inc = slot_cnt_r + 16'd1;
  assign mismatch  = slot_in.last && (count_inc != cfg.expected);

  always_comb begin
    valid_nxt    = valid_r;
    slot_cnt_nxt = slot_cnt_r;
    if (pop) begin
      valid_nxt    = 1'b1;
      // numbering restarts after the slot that ends the pattern
      slot_cnt_nxt = slot_in.last ? '0 : count_inc;
    end else if (!out_stall) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r    <= 1'b0;
      slot_cnt_r <= '0;
    end else begin
      valid_r    <= valid_nxt;
      slot_cnt_r <= slot_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      note_r     <= note_fix;
      instr_r    <= slot_in.fields[1];
      vol_r      <= slot_in.fields[2];
      fx_r       <= slot_in.fields[3];
      arg_r      <= slot_in.fields[4];
      number_r   <= slot_cnt_r;
      last_r     <= slot_in.last;
      mismatch_r <= mismatch;
    end
  end

  assign out_valid         = valid_r;
  assign note_value        = note_r;
  assign instrument_number = instr_r;
  assign volume_byte       = vol_r;
  assign effect_kind       = fx_r;
  assign effect_argument   = arg_r;
  assign slot_number       = number_r;
  assign last_slot         = last_r;
  assign count_mismatch    = mismatch_r;

endmodule

`default_nettype wire

/* design/tracker_pattern_unpacker.sv */
`timescale 1ns / 1ps
`default_nettype none

// Packed pattern unpacker: takes one byte of packed pattern data per cycle
// while in_stall is low and delivers one decoded slot per cycle unless
// out_stall holds it. The front end assembles packets (a mask byte plus the
// fields it flags, or a raw note plus four bytes) and hands each finished
// packet to a small slot queue of QUEUE_DEPTH entries; the back end fixes up
// the note, numbers the slot and checks the count against the expected count
// on the slot flagged last. A packet enters the queue as its closing byte is
// taken and is loaded into the output register once the output is free.
// in_stall is high only while the queue is full, so bytes flow at one per
// cycle as long as the result side takes slots. Configuration writes are
// always ready and must be made while no slot is in flight.
module tracker_pattern_unpacker #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire logic [7:0]                        in_data_byte,
  input  wire logic                              in_final_byte,
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic [7:0]                             out_note_value,
  output logic [7:0]                             out_instrument_number,
  output logic [7:0]                             out_volume_byte,
  output logic [7:0]                             out_effect_kind,
  output logic [7:0]                             out_effect_argument,
  output logic [15:0]                            out_slot_number,
  output logic                                   out_last_slot,
  output logic                                   out_count_mismatch,
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [tpu_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  wire logic [15:0]                       cfg_data
);

  tpu_pkg::cfg_t  cfg_r, cfg_nxt;
  tpu_pkg::slot_t push_data;
  tpu_pkg::slot_t pop_data;
  logic           push_valid;
  logic           pop;
  logic           q_not_empty;
  logic           q_full;

  assign cfg_ready = 1'b1;
  assign in_stall  = q_full;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        tpu_pkg::REG_KEY_OFF:  cfg_nxt.key_off  = cfg_data[7:0];
        tpu_pkg::REG_EXPECTED: cfg_nxt.expected = cfg_data;
        default:               cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.key_off  <= tpu_pkg::NOTE_OFF;
      cfg_r.expected <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  tpu_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .byte_valid (in_valid),
    .byte_stall (in_stall),
    .data_byte  (in_data_byte),
    .final_byte (in_final_byte),
    .push_data  (push_data),
    .push_valid (push_valid)
  );

  tpu_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push_valid),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (pop_data),
    .not_empty (q_not_empty),
    .full      (q_full)
  );

  tpu_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg               (cfg_r),
    .slot_avail        (q_not_empty),
    .slot_in           (pop_data),
    .pop               (pop),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .note_value        (out_note_value),
    .instrument_number (out_instrument_number),
    .volume_byte       (out_volume_byte),
    .effect_kind       (out_effect_kind),
    .effect_argument   (out_effect_argument),
    .slot_number       (out_slot_number),
    .last_slot         (out_last_slot),
    .count_mismatch    (out_count_mismatch)
  );

  // a count mismatch is only ever reported on the closing slot
  a_mismatch_on_last : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (!out_count_mismatch || out_last_slot))
    else $error("count mismatch on a slot that is not last");

  // numbering restarts after the closing slot
  a_restart_after_last : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_stall && out_last_slot) |=>
      (!out_valid || out_slot_number == 16'd0))
    else $error("slot numbering did not restart");

  // numbering steps by one within a pattern
  a_number_step : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_stall && !out_last_slot) |=>
      (!out_valid || out_slot_number == ($past(out_slot_number) + 16'd1)))
    else $error("slot number skipped or repeated");

endmodule

`default_nettype wire

/* tb/tracker_pattern_unpacker_test.sv */
`timescale 1ns / 1ps

module tracker_pattern_unpacker_test;

  localparam logic [7:0] MASK_FLAG = 8'h80;
  localparam int unsigned SETTLE_LIMIT = 2000;

  typedef struct packed {
    logic [7:0]  note;
    logic [7:0]  instrument;
    logic [7:0]  volume;
    logic [7:0]  effect;
    logic [7:0]  argument;
    logic [15:0] number;
    logic        last;
    logic        mismatch;
  } slot_rec_t;

  class slot_tracker;
    logic [7:0]                       key_off;
    logic [15:0]                      expected_count;
    logic [tpu_pkg::FIELD_N-1:0]      awaited;
    bit                               open_packet;
    logic [tpu_pkg::FIELD_N-1:0][7:0] gathered;
    logic [15:0]                      slot_count;
    slot_rec_t                        slots_due[$];
    int                               errors;
    int                               checked;
    int                               last_seen;
    int                               flagged;

    function new();
      key_off = tpu_pkg::NOTE_OFF;
      expected_count = '0;
      awaited = '0;
      open_packet = 0;
      gathered = '0;
      slot_count = '0;
      errors = 0;
      checked = 0;
      last_seen = 0;
      flagged = 0;
    endfunction

    function void write_reg(logic [tpu_pkg::CFG_INDEX_W-1:0] index, logic [15:0] value);
      case (index)
        tpu_pkg::REG_KEY_OFF: key_off = value[7:0];
        tpu_pkg::REG_EXPECTED: expected_count = value;
        default: ;
      endcase
    endfunction

    function void take_byte(logic [7:0] b, logic fin);
      int          pos;
      slot_rec_t   s;
      logic [15:0] next_count;
      if (!open_packet) begin
        gathered = '0;
        if (b[7]) begin
          awaited = b[tpu_pkg::FIELD_N-1:0];
        end else begin
          gathered[0] = b;
          awaited = tpu_pkg::MASK_RAW;
        end
        open_packet = 1;
      end else begin
        pos = 0;
        while (pos < tpu_pkg::FIELD_N && !awaited[pos]) pos++;
        if (pos < tpu_pkg::FIELD_N) begin
          gathered[pos] = b;
          awaited[pos] = 1'b0;
        end
      end
      if (awaited == '0 || fin) begin
        next_count = slot_count + 16'd1;
        s.note = gathered[0];
        if (s.note > tpu_pkg::NOTE_OFF) s.note = '0;
        else if (s.note == tpu_pkg::NOTE_OFF) s.note = key_off;
        s.instrument = gathered[1];
        s.volume = gathered[2];
        s.effect = gathered[3];
        s.argument = gathered[4];
        s.number = slot_count;
        s.last = fin;
        s.mismatch = fin && (next_count != expected_count);
        slots_due.push_back(s);
        awaited = '0;
        open_packet = 0;
        gathered = '0;
        slot_count = fin ? 16'd0 : next_count;
      end
    endfunction

    task report_mismatch(string msg);
      $display("%0t: %s", $time, msg);
      errors++;
    endtask

    task compare_field(int unsigned number, string name, int unsigned got, int unsigned want);
      if (got != want)
        report_mismatch($sformatf("slot %0d %s: got %0h, want %0h", number, name, got, want));
    endtask

    task check_slot(slot_rec_t got);
      slot_rec_t want;
      if (slots_due.size() == 0) begin
        report_mismatch($sformatf("slot %0d delivered with none due", got.number));
        return;
      end
      want = slots_due.pop_front();
      compare_field(want.number, "note", got.note, want.note);
      compare_field(want.number, "instrument", got.instrument, want.instrument);
      compare_field(want.number, "volume", got.volume, want.volume);
      compare_field(want.number, "effect", got.effect, want.effect);
      compare_field(want.number, "argument", got.argument, want.argument);
      compare_field(want.number, "slot number", got.number, want.number);
      compare_field(want.number, "last flag", got.last, want.last);
      compare_field(want.number, "count mismatch", got.mismatch, want.mismatch);
      checked++;
      if (got.last) last_seen++;
      if (got.mismatch) flagged++;
    endtask

    task flush_due();
      slot_rec_t lost;
      while (slots_due.size() != 0) begin
        lost = slots_due.pop_front();
        report_mismatch($sformatf("slot %0d never delivered", lost.number));
      end
    endtask
  endclass

  logic                            clk;
  logic                            rst_n;
  logic                            in_valid;
  logic                            in_stall;
  logic [7:0]                      in_data_byte;
  logic                            in_final_byte;
  logic                            out_valid;
  logic                            out_stall;
  logic [7:0]                      out_note_value;
  logic [7:0]                      out_instrument_number;
  logic [7:0]                      out_volume_byte;
  logic [7:0]                      out_effect_kind;
  logic [7:0]                      out_effect_argument;
  logic [15:0]                     out_slot_number;
  logic                            out_last_slot;
  logic                            out_count_mismatch;
  logic                            cfg_valid;
  logic                            cfg_ready;
  logic [tpu_pkg::CFG_INDEX_W-1:0] cfg_index;
  logic [15:0]                     cfg_data;

  slot_tracker sb;
  slot_rec_t   seen;
  logic [7:0]  pattern_bytes[$];
  bit          tx_idle_on;
  bit          rx_idle_on;
  int          bytes_sent;
  int          patterns_run;
  int          reg_writes;

  tracker_pattern_unpacker u_dut (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .in_valid              (in_valid),
    .in_stall              (in_stall),
    .in_data_byte          (in_data_byte),
    .in_final_byte         (in_final_byte),
    .out_valid             (out_valid),
    .out_stall             (out_stall),
    .out_note_value        (out_note_value),
    .out_instrument_number (out_instrument_number),
    .out_volume_byte       (out_volume_byte),
    .out_effect_kind       (out_effect_kind),
    .out_effect_argument   (out_effect_argument),
    .out_slot_number       (out_slot_number),
    .out_last_slot         (out_last_slot),
    .out_count_mismatch    (out_count_mismatch),
    .cfg_valid             (cfg_valid),
    .cfg_ready             (cfg_ready),
    .cfg_index             (cfg_index),
    .cfg_data              (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("FAIL tracker_pattern_unpacker");
    $finish;
  end

  // result side back-pressure in short bursts
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (rx_idle_on && $urandom_range(0, 4) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 4)) @(negedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      seen.note = out_note_value;
      seen.instrument = out_instrument_number;
      seen.volume = out_volume_byte;
      seen.effect = out_effect_kind;
      seen.argument = out_effect_argument;
      seen.number = out_slot_number;
      seen.last = out_last_slot;
      seen.mismatch = out_count_mismatch;
      sb.check_slot(seen);
    end
  end

  // called at a falling edge, returns at a falling edge with cfg_valid low
  task automatic cfg_write(input logic [tpu_pkg::CFG_INDEX_W-1:0] index,
                           input logic [15:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(index, value);
    reg_writes++;
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic set_key_off(input logic [7:0] code);
    logic [7:0] junk;
    junk = 8'($urandom_range(0, 255));
    // upper data bits carry noise, only the low byte counts
    cfg_write(tpu_pkg::REG_KEY_OFF, {junk, code});
  endtask

  task automatic send_byte(input logic [7:0] b, input logic fin);
    if (tx_idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data_byte <= b;
    in_final_byte <= fin;
    do @(posedge clk); while (in_stall);
    sb.take_byte(b, fin);
    bytes_sent++;
    @(negedge clk);
  endtask

  task automatic settle();
    int waited;
    waited = 0;
    in_valid <= 1'b0;
    while (sb.slots_due.size() != 0 && waited < SETTLE_LIMIT) begin
      @(negedge clk);
      waited++;
    end
    sb.flush_due();
    repeat (8) @(negedge clk);
  endtask

  task automatic play_pattern(input logic [15:0] expected_count);
    cfg_write(tpu_pkg::REG_EXPECTED, expected_count);
    foreach (pattern_bytes[k]) send_byte(pattern_bytes[k], k == pattern_bytes.size() - 1);
    settle();
    patterns_run++;
  endtask

  function automatic logic [7:0] pick_note();
    case ($urandom_range(0, 3))
      0: return tpu_pkg::NOTE_OFF;
      1: return tpu_pkg::NOTE_OFF + 8'd1;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic logic [7:0] pick_field();
    case ($urandom_range(0, 7))
      0: return 8'h00;
      1: return 8'hFF;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic append_packet(input bit truncate);
    logic [7:0] pk[$];
    logic [7:0] mask;
    int         keep;
    if ($urandom_range(0, 2) == 0) begin
      pk.push_back(pick_note() & 8'h7F);
      repeat (4) pk.push_back(pick_field());
    end else begin
      mask = 8'($urandom_range(0, 127));
      // now and then an empty mask, spare bits still random
      if ($urandom_range(0, 7) == 0) mask[tpu_pkg::FIELD_N-1:0] = '0;
      mask = mask | MASK_FLAG;
      pk.push_back(mask);
      if (mask[0]) pk.push_back(pick_note());
      for (int i = 1; i < tpu_pkg::FIELD_N; i++)
        if (mask[i]) pk.push_back(pick_field());
    end
    keep = truncate ? $urandom_range(1, pk.size()) : pk.size();
    for (int i = 0; i < keep; i++) pattern_bytes.push_back(pk[i]);
  endtask

  initial begin
    int          npk;
    bit          cut;
    logic [15:0] expected_count;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data_byte = '0;
    in_final_byte = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = tpu_pkg::REG_KEY_OFF;
    cfg_data = '0;
    tx_idle_on = 0;
    rx_idle_on = 0;
    bytes_sent = 0;
    patterns_run = 0;
    reg_writes = 0;
    sb = new();
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // full mask with a dropped note, raw note off, empty mask with spare bits,
    // note just above note off, raw packet cut short by the final byte
    set_key_off(8'hFF);
    pattern_bytes = {8'h9F, 8'hFF, 8'h00, 8'hFF, 8'h00, 8'h55,
                     8'h61, 8'hFF, 8'h80, 8'h01, 8'h7F,
                     8'hE0,
                     8'h81, 8'h62,
                     8'h60, 8'h33};
    play_pattern(16'd5);
    set_key_off(8'h00);
    pattern_bytes = {8'h61};
    play_pattern(16'd0);
    pattern_bytes = {8'hFF, 8'h7F, 8'h12};
    play_pattern(16'hFFFF);
    set_key_off(tpu_pkg::NOTE_OFF);
    pattern_bytes = {8'h80};
    play_pattern(16'd1);

    while (bytes_sent < 1200) begin
      tx_idle_on = (bytes_sent < 950) && ($urandom_range(0, 3) != 0);
      rx_idle_on = (bytes_sent < 950) && ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 3) == 0) begin
        case ($urandom_range(0, 3))
          0: set_key_off(8'h00);
          1: set_key_off(8'hFF);
          2: set_key_off(tpu_pkg::NOTE_OFF);
          default: set_key_off(8'($urandom_range(0, 255)));
        endcase
      end
      npk = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
      cut = ($urandom_range(0, 2) == 0);
      pattern_bytes.delete();
      for (int k = 0; k < npk; k++) append_packet(cut && k == npk - 1);
      case ($urandom_range(0, 7))
        0: expected_count = 16'd0;
        1: expected_count = 16'hFFFF;
        2: expected_count = 16'(npk + 1);
        3: expected_count = 16'(npk - 1);
        4: expected_count = 16'($urandom_range(0, 65535));
        default: expected_count = 16'(npk);
      endcase
      play_pattern(expected_count);
    end

    $display("%0d bytes over %0d patterns, %0d register writes", bytes_sent, patterns_run,
             reg_writes);
    $display("%0d slots compared, %0d closing a pattern, %0d with the count flag set",
             sb.checked, sb.last_seen, sb.flagged);
    if (sb.errors == 0) begin
      $display("PASS tracker_pattern_unpacker");
    end else begin
      $display("FAIL tracker_pattern_unpacker");
    end
    $finish;
  end

endmodule
